### hw/rtl/lcacs_pkg.sv
`default_nettype none
package lcacs_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int WEIGHT_W    = 32;
	localparam int FRAC_W      = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam int FILTER_LEN_W = 7;
	localparam int SMOOTHING_W  = 17;
	localparam int INV_SCALE_W  = 32;

	localparam logic [FILTER_LEN_W-1:0] FILTER_LENGTH_RST = 7'd20;
	localparam logic [SMOOTHING_W-1:0]  SMOOTHING_RST     = 17'd6554;
	localparam logic [SMOOTHING_W-1:0]  ALPHA_MIN         = 17'd655;
	localparam logic [SMOOTHING_W-1:0]  ALPHA_MAX         = 17'd65536;

	// Shared divider: magnitude dividend and divisor widths.
	localparam int DIV_NUM_W = 41;
	localparam int DIV_DEN_W = 17;

	localparam logic [DIV_DEN_W-1:0] DEN_TARE  = 17'd1000;
	localparam logic [DIV_DEN_W-1:0] HALF_TARE = 17'd500;
	localparam logic [DIV_DEN_W-1:0] DEN_RAW   = 17'd100000;
	localparam logic [DIV_DEN_W-1:0] HALF_RAW  = 17'd50000;

	localparam logic [FRAC_W:0] ROUND_HALF = 17'd32768;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FILTER_LENGTH = 3'd0,
		CFG_TARE_OFFSET   = 3'd1,
		CFG_IS_CALIBRATED = 3'd2,
		CFG_INVERSE_SCALE = 3'd3,
		CFG_SMOOTHING     = 3'd4
	} cfg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RING,
		S_AVG,
		S_SCALE,
		S_MUL_SCALE,
		S_DIV_SCALE,
		S_SMOOTH,
		S_MUL_STEP,
		S_UPDATE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                      start;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage
`default_nettype wire

### hw/rtl/lcacs_ring.sv
`default_nettype none
module lcacs_ring #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [AW-1:0]                         waddr,
	input  logic signed [lcacs_pkg::SAMPLE_W-1:0] wdata,
	input  logic [AW-1:0]                         raddr,
	output logic signed [lcacs_pkg::SAMPLE_W-1:0] rdata
);
	import lcacs_pkg::*;

	logic signed [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/lcacs_div.sv
`default_nettype none
module lcacs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lcacs_pkg::div_req_t             req,
	output logic                            done,
	output logic [lcacs_pkg::DIV_NUM_W-1:0] quo
);
	import lcacs_pkg::*;

	localparam int STEP_W = $clog2(DIV_NUM_W);

	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [STEP_W-1:0]    step_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W:0]   rem_sub;
	logic                 fits;

	// Restoring division: the dividend shifts out of the top of quo_q while
	// quotient bits shift in at the bottom.
	assign rem_sh  = {rem_q, quo_q[DIV_NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign fits    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(DIV_NUM_W - 1);
			end else if (run_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end else if (run_q) begin
			rem_q <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

### hw/rtl/lcacs_mul.sv
`default_nettype none
module lcacs_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lcacs_pkg::mul_req_t                  req,
	output logic                                 done,
	output logic signed [lcacs_pkg::MUL_P_W-1:0] p
);
	import lcacs_pkg::*;

	logic signed [MUL_P_W-1:0] prod;
	logic signed [MUL_P_W-1:0] p_q;
	logic                      done_q;

	assign prod = req.a * req.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			p_q <= prod;
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule
`default_nettype wire

### hw/rtl/load_cell_average_calibrate_smooth.sv
// A request takes longer with a fallback divisor than with the calibrated scale, since the
// fallback scaling makes a second pass through the divider; out_valid also waits for out_ready.
// One request is in flight at a time; the 41-step radix-2 divider is used once for the
// average and once for the fallback scaling.
// Reset (arst_n, asynchronous, active low) clears the sequencer, the ring pointer,
// running sum, smoother and configuration registers; the sample ring itself is never cleared.
`default_nettype none
module load_cell_average_calibrate_smooth #(
	parameter int MAX_TAPS = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [lcacs_pkg::SAMPLE_W-1:0]   sample,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [lcacs_pkg::SAMPLE_W-1:0]   average,
	output logic signed [lcacs_pkg::WEIGHT_W-1:0]   weight,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [lcacs_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [lcacs_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import lcacs_pkg::*;

	localparam int SLOT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_W  = $clog2(MAX_TAPS + 1);
	localparam int SUM_W  = SAMPLE_W + $clog2(MAX_TAPS) + 1;
	localparam int D_W    = SAMPLE_W + 1;
	localparam int RND_W  = MUL_P_W - FRAC_W + 1;
	localparam int SAT_W  = RND_W + 1;

	function automatic logic signed [RND_W-1:0] rnd16(input logic signed [MUL_P_W-1:0] v);
		logic [MUL_P_W-1:0] mag;
		logic [MUL_P_W-1:0] q;
		mag = v[MUL_P_W-1] ? -v : v;
		q = (mag + MUL_P_W'(ROUND_HALF)) >> FRAC_W;
		rnd16 = v[MUL_P_W-1] ? -signed'(q[RND_W-1:0]) : signed'(q[RND_W-1:0]);
	endfunction

	function automatic logic signed [WEIGHT_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-WEIGHT_W:0] top;
		top = v[SAT_W-1:WEIGHT_W-1];
		if (top == '0 || top == '1) begin
			sat32 = v[WEIGHT_W-1:0];
		end else if (v[SAT_W-1]) begin
			sat32 = WEIGHT_MIN;
		end else begin
			sat32 = WEIGHT_MAX;
		end
	endfunction

	state_t state_q;
	state_t state_d;

	// Configuration registers.
	logic [FILTER_LEN_W-1:0]         filter_length_q;
	logic signed [SAMPLE_W-1:0]      tare_q;
	logic                            is_cal_q;
	logic signed [INV_SCALE_W-1:0]   inv_scale_q;
	logic [SMOOTHING_W-1:0]          smoothing_q;
	logic                            cfg_fire;
	logic                            restart;

	// Block state.
	logic [SLOT_W-1:0]               write_slot_q;
	logic                            ring_full_q;
	logic signed [SUM_W-1:0]         sum_q;
	logic signed [WEIGHT_W-1:0]      smooth_q;
	logic                            started_q;
	logic                            out_valid_q;

	// Per-request working registers.
	logic signed [SAMPLE_W-1:0]      sample_q;
	logic                            neg_q;
	logic signed [SAMPLE_W-1:0]      avg_q;
	logic signed [WEIGHT_W-1:0]      instant_q;
	logic signed [RND_W-1:0]         step_q;
	logic signed [SAMPLE_W-1:0]      average_q;
	logic signed [WEIGHT_W-1:0]      weight_q;

	// Sequencer outputs.
	logic                            div_start;
	logic                            mul_start;
	logic                            ring_we;
	logic                            out_load;

	// Ring update.
	logic [CNT_W-1:0]                taps_len;
	logic [CNT_W-1:0]                slot_inc;
	logic                            wrap;
	logic [CNT_W-1:0]                count_new;
	logic signed [SAMPLE_W-1:0]      ring_rdata;
	logic signed [SUM_W-1:0]         old_term;
	logic signed [SUM_W-1:0]         sum_new;
	logic [SUM_W-1:0]                sum_mag;

	// Scaling.
	logic                            use_cal;
	logic                            tare_set;
	logic signed [D_W-1:0]           d_val;
	logic signed [D_W-1:0]           base;
	logic [D_W-1:0]                  base_mag;
	logic [DIV_NUM_W-1:0]            scale_num;
	logic [DIV_DEN_W-1:0]            scale_den;
	logic [DIV_DEN_W-1:0]            scale_half;
	logic [SMOOTHING_W-1:0]          alpha_c;
	logic signed [MUL_A_W-1:0]       diff;

	// Shared units.
	div_req_t                        div_req;
	logic                            div_done;
	logic [DIV_NUM_W-1:0]            div_quo;
	logic signed [DIV_NUM_W:0]       quo_sv;
	mul_req_t                        mul_req;
	logic                            mul_done;
	logic signed [MUL_P_W-1:0]       mul_p;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign restart   = cfg_fire && (cfg_index == CFG_FILTER_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_length_q <= FILTER_LENGTH_RST;
			tare_q          <= '0;
			is_cal_q        <= 1'b0;
			inv_scale_q     <= '0;
			smoothing_q     <= SMOOTHING_RST;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				CFG_FILTER_LENGTH: filter_length_q <= cfg_data[FILTER_LEN_W-1:0];
				CFG_TARE_OFFSET:   tare_q          <= signed'(cfg_data[SAMPLE_W-1:0]);
				CFG_IS_CALIBRATED: is_cal_q        <= cfg_data[0];
				CFG_INVERSE_SCALE: inv_scale_q     <= signed'(cfg_data[INV_SCALE_W-1:0]);
				CFG_SMOOTHING:     smoothing_q     <= cfg_data[SMOOTHING_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (filter_length_q == '0) begin
			taps_len = CNT_W'(1);
		end else if (32'(filter_length_q) > MAX_TAPS) begin
			taps_len = CNT_W'(MAX_TAPS);
		end else begin
			taps_len = CNT_W'(filter_length_q);
		end
	end

	lcacs_ring #(
		.DEPTH (MAX_TAPS),
		.AW    (SLOT_W)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (write_slot_q),
		.wdata (sample_q),
		.raddr (write_slot_q),
		.rdata (ring_rdata)
	);

	assign slot_inc  = CNT_W'(write_slot_q) + CNT_W'(1);
	assign wrap      = slot_inc >= taps_len;
	assign count_new = (wrap || ring_full_q) ? taps_len : slot_inc;
	assign old_term  = ring_full_q ? SUM_W'(ring_rdata) : '0;
	assign sum_new   = sum_q - old_term + SUM_W'(sample_q);
	assign sum_mag   = sum_new[SUM_W-1] ? -sum_new : sum_new;

	assign use_cal    = is_cal_q && (inv_scale_q != '0);
	assign tare_set   = tare_q != '0;
	assign d_val      = D_W'(avg_q) - D_W'(tare_q);
	assign base       = tare_set ? d_val : D_W'(avg_q);
	assign base_mag   = base[D_W-1] ? -base : base;
	assign scale_den  = tare_set ? DEN_TARE : DEN_RAW;
	assign scale_half = tare_set ? HALF_TARE : HALF_RAW;
	assign scale_num  = DIV_NUM_W'({base_mag, {FRAC_W{1'b0}}}) + DIV_NUM_W'(scale_half);

	always_comb begin
		if (smoothing_q < ALPHA_MIN) begin
			alpha_c = ALPHA_MIN;
		end else if (smoothing_q > ALPHA_MAX) begin
			alpha_c = ALPHA_MAX;
		end else begin
			alpha_c = smoothing_q;
		end
	end

	assign diff = MUL_A_W'(instant_q) - MUL_A_W'(smooth_q);

	// The divider serves the average in S_RING and the fallback scaling in S_SCALE.
	always_comb begin
		div_req.start = div_start;
		if (state_q == S_RING) begin
			div_req.num = DIV_NUM_W'(sum_mag);
			div_req.den = DIV_DEN_W'(count_new);
		end else begin
			div_req.num = scale_num;
			div_req.den = scale_den;
		end
	end

	lcacs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign quo_sv = neg_q ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});

	always_comb begin
		mul_req.start = mul_start;
		if (state_q == S_SCALE) begin
			mul_req.a = MUL_A_W'(d_val);
			mul_req.b = inv_scale_q;
		end else begin
			mul_req.a = diff;
			mul_req.b = MUL_B_W'(signed'({1'b0, alpha_c}));
		end
	end

	lcacs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.p      (mul_p)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_d = S_RING;
			S_RING:      state_d = S_AVG;
			S_AVG:       if (div_done) state_d = S_SCALE;
			S_SCALE:     state_d = use_cal ? S_MUL_SCALE : S_DIV_SCALE;
			S_MUL_SCALE: state_d = S_SMOOTH;
			S_DIV_SCALE: if (div_done) state_d = S_SMOOTH;
			S_SMOOTH:    state_d = started_q ? S_MUL_STEP : S_OUT;
			S_MUL_STEP:  state_d = S_UPDATE;
			S_UPDATE:    state_d = S_OUT;
			S_OUT:       if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = state_q == S_IDLE;
		ring_we   = state_q == S_RING;
		div_start = (state_q == S_RING) || (state_q == S_SCALE && !use_cal);
		mul_start = (state_q == S_SCALE && use_cal) || (state_q == S_SMOOTH && started_q);
		out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			ring_full_q  <= 1'b0;
			sum_q        <= '0;
			smooth_q     <= '0;
			started_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (restart) begin
				write_slot_q <= '0;
				ring_full_q  <= 1'b0;
				sum_q        <= '0;
			end else if (state_q == S_RING) begin
				write_slot_q <= wrap ? '0 : slot_inc[SLOT_W-1:0];
				ring_full_q  <= ring_full_q || wrap;
				sum_q        <= sum_new;
			end

			if (state_q == S_SMOOTH && !started_q) begin
				smooth_q  <= instant_q;
				started_q <= 1'b1;
			end else if (state_q == S_UPDATE) begin
				smooth_q <= sat32(SAT_W'(smooth_q) + SAT_W'(step_q));
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_q <= sample;
		end
		if (state_q == S_RING) begin
			neg_q <= sum_new[SUM_W-1];
		end else if (state_q == S_SCALE) begin
			neg_q <= base[D_W-1];
		end
		if (state_q == S_AVG && div_done) begin
			avg_q <= quo_sv[SAMPLE_W-1:0];
		end
		if (state_q == S_MUL_SCALE) begin
			instant_q <= sat32(SAT_W'(rnd16(mul_p)));
		end else if (state_q == S_DIV_SCALE && div_done) begin
			instant_q <= sat32(SAT_W'(quo_sv));
		end
		if (state_q == S_MUL_STEP) begin
			step_q <= rnd16(mul_p);
		end
		if (out_load) begin
			average_q <= avg_q;
			weight_q  <= smooth_q;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign weight    = weight_q;

`ifndef ASSERT_OFF
	// The write pointer always stays inside the active filter length.
	a_slot_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(write_slot_q) < taps_len)
		else $error("ring write slot outside active length");

	// An empty ring (just restarted) must carry no running sum.
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(!ring_full_q && write_slot_q == '0) |-> sum_q == '0)
		else $error("running sum nonzero on empty ring");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_AVG || state_q == S_DIV_SCALE))
		else $error("divider finished outside a divide wait state");

	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL_SCALE || state_q == S_MUL_STEP))
		else $error("multiplier result outside a multiply state");
`endif

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import lcacs_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 120;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 78;

	localparam int TAPS_MAX = 64;
	localparam longint Q16_ONE = 65536;
	localparam longint TARE_DIVISOR = 1000;
	localparam longint RAW_DIVISOR = 100000;
	localparam longint ALPHA_LO = 655;
	localparam longint ALPHA_HI = 65536;
	localparam logic [6:0] LEN_AT_RESET = 7'd20;
	localparam logic [16:0] ALPHA_AT_RESET = 17'd6554;

	localparam int SAMPLE_TOP = 8388607;
	localparam int SAMPLE_BOTTOM = -8388608;
	localparam logic [23:0] AVG_TOP = 24'h7f_ffff;
	localparam logic [23:0] AVG_BOTTOM = 24'h80_0000;

	localparam logic [2:0] NO_INDEX = 3'd0;
	localparam logic [2:0] CFG_SPARE_LO = 3'd5;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [23:0] average;
		logic [31:0] weight;
	} load_reading_t;

	typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  index;
		logic [31:0] data;
		logic        typed;
		logic [23:0] want_avg;
		logic [31:0] want_weight;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 45;

	// Rows with typed results can be worked out by hand; the others go through the predictor.
	stim_row_t directed [DIRECTED_ROWS] = '{
		'{ROW_SAMPLE, NO_INDEX, 32'd100000, 1'b1, 24'd100000, 32'd65536},
		'{ROW_SAMPLE, NO_INDEX, 32'd0, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_FILTER_LENGTH, 32'd1, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, SAMPLE_TOP, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, SAMPLE_BOTTOM, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_SMOOTHING, 32'd65536, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, -32'sd100000, 1'b1, -24'sd100000, -32'sd65536},
		'{ROW_WRITE, CFG_TARE_OFFSET, 32'd1000, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, 32'd2000, 1'b1, 24'd2000, 32'd65536},
		'{ROW_WRITE, CFG_TARE_OFFSET, SAMPLE_BOTTOM, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, SAMPLE_TOP, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_IS_CALIBRATED, 32'd1, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, SAMPLE_BOTTOM, 1'b1, AVG_BOTTOM, 32'd0},
		'{ROW_WRITE, CFG_INVERSE_SCALE, 32'h7fff_ffff, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, SAMPLE_TOP, 1'b1, AVG_TOP, WEIGHT_MAX},
		'{ROW_WRITE, CFG_INVERSE_SCALE, 32'h8000_0000, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, SAMPLE_TOP, 1'b1, AVG_TOP, WEIGHT_MIN},
		'{ROW_WRITE, CFG_TARE_OFFSET, 32'd0, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_INVERSE_SCALE, 32'd32768, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, -32'sd1, 1'b1, -24'sd1, -32'sd1},
		'{ROW_SAMPLE, NO_INDEX, 32'd1, 1'b1, 24'd1, 32'd1},
		'{ROW_WRITE, CFG_SMOOTHING, 32'd32768, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, 32'd0, 1'b1, 24'd0, 32'd0},
		'{ROW_SAMPLE, NO_INDEX, -32'sd2, 1'b1, -24'sd2, -32'sd1},
		'{ROW_WRITE, CFG_SMOOTHING, 32'd0, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, 32'd123456, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_SMOOTHING, 32'h0001_ffff, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, -32'sd654321, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_FILTER_LENGTH, 32'd0, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, 32'd77, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_FILTER_LENGTH, 32'd4, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, -32'sd5, 1'b1, -24'sd5, -32'sd3},
		'{ROW_SAMPLE, NO_INDEX, 32'd0, 1'b1, -24'sd2, -32'sd1},
		'{ROW_SAMPLE, NO_INDEX, 32'd3, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, 32'd7, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, 32'd9, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_FILTER_LENGTH, 32'd127, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, SAMPLE_TOP, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, SAMPLE_TOP, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_SPARE_LO, 32'hffff_ffff, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_SPARE_HI, 32'hffff_ffff, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, SAMPLE_BOTTOM, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_IS_CALIBRATED, 32'd0, 1'b0, '0, '0},
		'{ROW_WRITE, CFG_FILTER_LENGTH, 32'd64, 1'b0, '0, '0},
		'{ROW_SAMPLE, NO_INDEX, SAMPLE_BOTTOM, 1'b0, '0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] average;
	logic signed [WEIGHT_W-1:0] weight;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	load_cell_average_calibrate_smooth i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average(average),
		.weight(weight),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow of the block's state and registers.
	logic signed [23:0] avg_ring [TAPS_MAX];
	int unsigned avg_slot = 0;
	bit avg_full = 1'b0;
	longint avg_sum = 0;
	longint smooth_weight = 0;
	bit smooth_seeded = 1'b0;
	logic [6:0] r_filter_length = LEN_AT_RESET;
	logic signed [23:0] r_tare = '0;
	logic r_calibrated = 1'b0;
	logic signed [31:0] r_inv_scale = '0;
	logic [16:0] r_alpha = ALPHA_AT_RESET;

	load_reading_t pending_readings [$];
	load_reading_t oldest;
	int error_count = 0;
	bit no_idle = 1'b0;
	bit sender_gaps = 1'b1;
	int ready_left = 0;

	function automatic longint round_half_away(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint clamp_weight(input longint v);
		if (v > longint'(WEIGHT_MAX)) return longint'(WEIGHT_MAX);
		if (v < longint'(WEIGHT_MIN)) return longint'(WEIGHT_MIN);
		return v;
	endfunction

	function automatic load_reading_t condition_sample(input logic signed [23:0] s);
		int unsigned taps;
		int unsigned slot;
		int unsigned count;
		longint avg;
		longint instant;
		longint alpha;
		load_reading_t reading;
		taps = (r_filter_length == 0) ? 1 : (r_filter_length > TAPS_MAX) ? TAPS_MAX : r_filter_length;
		slot = avg_slot % taps;
		if (avg_full) avg_sum -= avg_ring[slot];
		avg_ring[slot] = s;
		avg_sum += s;
		slot++;
		if (slot >= taps) begin
			slot = 0;
			avg_full = 1'b1;
		end
		avg_slot = slot;
		count = avg_full ? taps : slot;
		avg = avg_sum / longint'(count);

		if (r_calibrated && r_inv_scale != 0)
			instant = round_half_away((avg - longint'(r_tare)) * longint'(r_inv_scale), Q16_ONE);
		else if (r_tare != 0)
			instant = round_half_away((avg - longint'(r_tare)) * Q16_ONE, TARE_DIVISOR);
		else
			instant = round_half_away(avg * Q16_ONE, RAW_DIVISOR);
		instant = clamp_weight(instant);

		if (!smooth_seeded) begin
			smooth_weight = instant;
			smooth_seeded = 1'b1;
		end else begin
			alpha = r_alpha;
			if (alpha < ALPHA_LO) alpha = ALPHA_LO;
			if (alpha > ALPHA_HI) alpha = ALPHA_HI;
			smooth_weight = clamp_weight(smooth_weight +
				round_half_away(alpha * (instant - smooth_weight), Q16_ONE));
		end
		reading.average = avg[23:0];
		reading.weight = smooth_weight[31:0];
		return reading;
	endfunction

	task automatic push_sample(input logic [23:0] value, input logic typed,
			input load_reading_t typed_reading);
		load_reading_t predicted;
		if (sender_gaps && !no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (!in_ready);
		predicted = condition_sample(value);
		pending_readings.push_back(typed ? typed_reading : predicted);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FILTER_LENGTH: begin
				r_filter_length = data[6:0];
				avg_slot = 0;
				avg_full = 1'b0;
				avg_sum = 0;
			end
			CFG_TARE_OFFSET: r_tare = data[23:0];
			CFG_IS_CALIBRATED: r_calibrated = data[0];
			CFG_INVERSE_SCALE: r_inv_scale = data;
			CFG_SMOOTHING: r_alpha = data[16:0];
			default: ;
		endcase
	endtask

	// Holds off new requests until every outstanding result has come back.
	task automatic await_idle();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (no_idle) begin
			out_ready <= 1'b1;
		end else if (ready_left > 0) begin
			ready_left--;
		end else if ($urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			ready_left = $urandom_range(0, 16);
		end else begin
			out_ready <= 1'b1;
			ready_left = $urandom_range(0, 60);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				error_count++;
				$display("%0t: result with nothing expected, actual average %0d weight %0d",
					$time, average, weight);
			end else begin
				oldest = pending_readings.pop_front();
				if (average !== oldest.average) begin
					error_count++;
					$display("%0t: average mismatch, expected %0d, actual %0d",
						$time, $signed(oldest.average), average);
				end
				if (weight !== oldest.weight) begin
					error_count++;
					$display("%0t: weight mismatch, expected %0d, actual %0d",
						$time, $signed(oldest.weight), weight);
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		bit cfg_open;
		int pick;
		int v;
		int load_center;
		int noise_bits;
		logic [31:0] word;

		cfg_open = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed[r].kind == ROW_WRITE) begin
				if (!cfg_open) await_idle();
				write_reg(directed[r].index, directed[r].data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
				end
				push_sample(directed[r].data[23:0], directed[r].typed,
					{directed[r].want_avg, directed[r].want_weight});
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			await_idle();
			no_idle = (phase == PHASES - 1);
			sender_gaps = ($urandom_range(0, 2) != 0);
			load_center = int'($urandom) >>> 8;
			noise_bits = $urandom_range(0, 12);

			if (phase == 0 || $urandom_range(0, 4) != 0) begin
				pick = $urandom_range(0, 9);
				word = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 : (pick == 2) ? 32'd64 :
					(pick == 3) ? 32'($urandom_range(65, 127)) : 32'($urandom_range(1, 64));
				write_reg(CFG_FILTER_LENGTH, word | ($urandom & 32'hffff_ff80));
				cfg_open = 1'b1;
			end
			if ($urandom_range(0, 1) == 1) begin
				pick = $urandom_range(0, 5);
				word = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom :
					(pick == 2) ? SAMPLE_TOP : (pick == 3) ? SAMPLE_BOTTOM :
					32'(load_center + int'($urandom_range(0, 2000)) - 1000);
				write_reg(CFG_TARE_OFFSET, word);
				cfg_open = 1'b1;
			end
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_IS_CALIBRATED, $urandom);
				cfg_open = 1'b1;
			end
			if ($urandom_range(0, 1) == 1) begin
				pick = $urandom_range(0, 4);
				if (pick == 0) begin
					word = 32'd0;
				end else if (pick == 1) begin
					word = $urandom;
				end else begin
					// Realistic scales keep most weights clear of saturation.
					word = $urandom_range(1, 1 << 22);
					if ($urandom_range(0, 1) == 1) word = -word;
				end
				write_reg(CFG_INVERSE_SCALE, word);
				cfg_open = 1'b1;
			end
			if ($urandom_range(0, 1) == 1) begin
				pick = $urandom_range(0, 5);
				word = (pick == 0) ? 32'(ALPHA_LO) : (pick == 1) ? 32'(ALPHA_HI) :
					(pick == 2) ? $urandom : 32'($urandom_range(ALPHA_LO, ALPHA_HI));
				write_reg(CFG_SMOOTHING, word);
				cfg_open = 1'b1;
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
				end
				pick = $urandom_range(0, 19);
				if (pick < 12) begin
					// A steady load with converter noise around it.
					v = load_center + int'($urandom_range(0, 2 << noise_bits)) - (1 << noise_bits);
					if (v > SAMPLE_TOP) v = SAMPLE_TOP;
					if (v < SAMPLE_BOTTOM) v = SAMPLE_BOTTOM;
				end else if (pick < 17) begin
					v = int'($urandom);
				end else begin
					case ($urandom_range(0, 4))
						0: v = SAMPLE_TOP;
						1: v = SAMPLE_BOTTOM;
						2: v = 0;
						3: v = -1;
						default: v = 1;
					endcase
				end
				push_sample(v[23:0], 1'b0, '0);
			end
		end

		await_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
